// File: rtl/lsrv_pkg.sv
// Package for the LCG skip-ahead random vector generator.
// Holds widths, register indexes, generator constants and the command and
// status types shared by the controller, the datapath and the top level.
`default_nettype none

package lsrv_pkg;

  localparam int unsigned RUN_W     = 7;
  localparam int unsigned MAX_RUN   = 64;
  localparam int unsigned JUMP_W    = 50;
  localparam int unsigned VAL_W     = 49;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 64;

  localparam logic [63:0] LCG_MUL = 64'd6364136223846793005;
  localparam logic [63:0] LCG_INC = 64'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEED         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SHIFT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GLOBAL_SIZE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_REAL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_IMAG   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLEX_MODE = 3'd5;

  localparam logic [1:0] MPH_LOLO = 2'd0;
  localparam logic [1:0] MPH_LOHI = 2'd1;
  localparam logic [1:0] MPH_HILO = 2'd2;
  localparam logic [1:0] MPH_LAST = 2'd3;

  typedef enum logic [3:0] {
    MS_COLGS,
    MS_PM_GEN,
    MS_PI_PM1,
    MS_PM_PM,
    MS_GEN_LCG,
    MS_DR_SR,
    MS_DI_SI,
    MS_DR_SI,
    MS_DI_SR
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_JUMP_LOAD,
    OP_GEN_JUMP,
    OP_PI,
    OP_PM,
    OP_DRAW_R,
    OP_DRAW_I,
    OP_GEN_STEP,
    OP_RE_FIRST,
    OP_RE_SUB,
    OP_IM_FIRST,
    OP_IM_ADD,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_JCALC,
    S_JLOAD,
    S_JTEST,
    S_JGEN,
    S_JPI,
    S_JPM,
    S_EMIT_CHK,
    S_D1,
    S_D2GO,
    S_D2,
    S_P0GO,
    S_P0,
    S_P1,
    S_P2,
    S_P3,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic     mul_start;
    mul_sel_t mul_sel;
    dp_op_t   op;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic jump_zero;
    logic jump_lsb;
    logic left_zero;
    logic cplx;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/lsrv_mul.sv
// Shared multiplier unit: one registered 33x33 signed multiplier.
// Wide mode returns the low 64 bits of a 64x64 product from three partial
// products; narrow mode returns a signed 33x33 product. Uses lsrv_pkg.
`default_nettype none

module lsrv_mul
  import lsrv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        wide,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      result
);

  logic [63:0]        a_r;
  logic [63:0]        b_r;
  logic               wide_r;
  logic               busy_r;
  logic               done_r;
  logic [1:0]         ph_r;
  logic [63:0]        prod_r;
  logic [63:0]        acc_r;
  logic signed [32:0] ma;
  logic signed [32:0] mb;
  logic signed [65:0] prod_full;
  logic               last_ph;

  always_comb begin
    case (ph_r)
      MPH_LOLO: begin
        ma = wide_r ? {1'b0, a_r[31:0]} : a_r[32:0];
        mb = wide_r ? {1'b0, b_r[31:0]} : b_r[32:0];
      end
      MPH_LOHI: begin
        ma = {1'b0, a_r[31:0]};
        mb = {1'b0, b_r[63:32]};
      end
      MPH_HILO: begin
        ma = {1'b0, a_r[63:32]};
        mb = {1'b0, b_r[31:0]};
      end
      default: begin
        ma = {1'b0, a_r[31:0]};
        mb = {1'b0, b_r[31:0]};
      end
    endcase
  end

  assign prod_full = ma * mb;
  assign last_ph   = (ph_r == MPH_LAST) || ((ph_r == MPH_LOHI) && !wide_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= MPH_LOLO;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= MPH_LOLO;
      end else if (busy_r) begin
        ph_r <= ph_r + 2'd1;
        if (last_ph) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r    <= a;
      b_r    <= b;
      wide_r <= wide;
    end
    if (busy_r) begin
      prod_r <= prod_full[63:0];
      case (ph_r)
        MPH_LOHI: acc_r <= prod_r;
        MPH_HILO: acc_r <= acc_r + {prod_r[31:0], 32'h0};
        MPH_LAST: acc_r <= acc_r + {prod_r[31:0], 32'h0};
        default:  acc_r <= acc_r;
      endcase
    end
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

// File: rtl/lsrv_ctrl.sv
// Controller state machine for the skip-ahead generator.
// Sequences the jump, the draws and the scaling products as datapath commands.
// Depends on lsrv_pkg.
`default_nettype none

module lsrv_ctrl
  import lsrv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire dp_status_t status,
  output logic            busy,
  output dp_cmd_t         cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (start) state_nxt = S_JCALC;
      S_JCALC:    state_nxt = S_JLOAD;
      S_JLOAD:    if (status.mul_done) state_nxt = S_JTEST;
      S_JTEST: begin
        if (status.jump_zero) state_nxt = S_EMIT_CHK;
        else if (status.jump_lsb) state_nxt = S_JGEN;
        else state_nxt = S_JPI;
      end
      S_JGEN:     if (status.mul_done) state_nxt = S_JPI;
      S_JPI:      if (status.mul_done) state_nxt = S_JPM;
      S_JPM:      if (status.mul_done) state_nxt = S_JTEST;
      S_EMIT_CHK: state_nxt = status.left_zero ? S_IDLE : S_D1;
      S_D1:       if (status.mul_done) state_nxt = status.cplx ? S_D2GO : S_P0GO;
      S_D2GO:     state_nxt = S_D2;
      S_D2:       if (status.mul_done) state_nxt = S_P0GO;
      S_P0GO:     state_nxt = S_P0;
      S_P0:       if (status.mul_done) state_nxt = status.cplx ? S_P1 : S_OUT;
      S_P1:       if (status.mul_done) state_nxt = S_P2;
      S_P2:       if (status.mul_done) state_nxt = S_P3;
      S_P3:       if (status.mul_done) state_nxt = S_OUT;
      S_OUT:      state_nxt = S_EMIT_CHK;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = MS_COLGS;
    cmd.op        = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (start) cmd.op = OP_ACCEPT;
      end
      S_JCALC: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_COLGS;
      end
      S_JLOAD: begin
        if (status.mul_done) cmd.op = OP_JUMP_LOAD;
      end
      S_JTEST: begin
        if (!status.jump_zero) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = status.jump_lsb ? MS_PM_GEN : MS_PI_PM1;
        end
      end
      S_JGEN: begin
        if (status.mul_done) begin
          cmd.op        = OP_GEN_JUMP;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_PI_PM1;
        end
      end
      S_JPI: begin
        if (status.mul_done) begin
          cmd.op        = OP_PI;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_PM_PM;
        end
      end
      S_JPM: begin
        if (status.mul_done) cmd.op = OP_PM;
      end
      S_EMIT_CHK: begin
        if (!status.left_zero) begin
          cmd.op        = OP_DRAW_R;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_GEN_LCG;
        end
      end
      S_D1: begin
        if (status.mul_done) cmd.op = OP_GEN_STEP;
      end
      S_D2GO: begin
        cmd.op        = OP_DRAW_I;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_GEN_LCG;
      end
      S_D2: begin
        if (status.mul_done) cmd.op = OP_GEN_STEP;
      end
      S_P0GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MS_DR_SR;
      end
      S_P0: begin
        if (status.mul_done) begin
          cmd.op        = OP_RE_FIRST;
          cmd.mul_start = status.cplx;
          cmd.mul_sel   = MS_DI_SI;
        end
      end
      S_P1: begin
        if (status.mul_done) begin
          cmd.op        = OP_RE_SUB;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_DR_SI;
        end
      end
      S_P2: begin
        if (status.mul_done) begin
          cmd.op        = OP_IM_FIRST;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = MS_DI_SR;
        end
      end
      S_P3: begin
        if (status.mul_done) cmd.op = OP_IM_ADD;
      end
      S_OUT: begin
        cmd.op = OP_EMIT;
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

`default_nettype wire

// File: rtl/lsrv_datapath.sv
// Datapath of the skip-ahead generator: configuration registers, generator
// state, jump powers, draws, scaled sums and the result registers.
// Depends on lsrv_pkg and lsrv_mul.
`default_nettype none

module lsrv_datapath
  import lsrv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data,
  input  wire logic [31:0]           in_start_row,
  input  wire logic [15:0]           in_rhs_column,
  input  wire logic [RUN_W-1:0]      in_run_length,
  output logic                       out_strobe,
  output logic signed [VAL_W-1:0]    out_value_real,
  output logic signed [VAL_W-1:0]    out_value_imag,
  output logic                       out_last_in_run
);

  logic [63:0]              seed_r;
  logic [30:0]              shift_r;
  logic [31:0]              gsize_r;
  logic signed [31:0]       sr_r;
  logic signed [31:0]       si_r;
  logic                     cplx_r;

  logic [31:0]              row_r;
  logic [15:0]              col_r;
  logic [RUN_W-1:0]         left_r;
  logic [JUMP_W-1:0]        jump_r;
  logic [63:0]              gen_r;
  logic [63:0]              pm_r;
  logic [63:0]              pi_r;
  logic signed [32:0]       dr_r;
  logic signed [32:0]       di_r;
  logic signed [VAL_W-1:0]  re_r;
  logic signed [VAL_W-1:0]  im_r;

  logic                     out_strobe_r;
  logic signed [VAL_W-1:0]  out_re_r;
  logic signed [VAL_W-1:0]  out_im_r;
  logic                     out_last_r;

  logic                     mul_wide;
  logic [63:0]              mul_a;
  logic [63:0]              mul_b;
  logic                     mul_done;
  logic [63:0]              mul_res;
  logic signed [VAL_W-1:0]  res_sh;
  logic [JUMP_W-1:0]        jump_sum;
  logic [RUN_W-1:0]         len_sat;
  logic signed [32:0]       draw_now;

  lsrv_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .wide   (mul_wide),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  always_comb begin
    mul_wide = 1'b1;
    mul_a    = gen_r;
    mul_b    = LCG_MUL;
    case (cmd.mul_sel)
      MS_COLGS: begin
        mul_wide = 1'b0;
        mul_a    = {48'h0, col_r};
        mul_b    = {32'h0, gsize_r};
      end
      MS_PM_GEN: begin
        mul_a = pm_r;
        mul_b = gen_r;
      end
      MS_PI_PM1: begin
        mul_a = pi_r;
        mul_b = pm_r + 64'd1;
      end
      MS_PM_PM: begin
        mul_a = pm_r;
        mul_b = pm_r;
      end
      MS_GEN_LCG: begin
        mul_a = gen_r;
        mul_b = LCG_MUL;
      end
      MS_DR_SR: begin
        mul_wide = 1'b0;
        mul_a    = {{31{dr_r[32]}}, dr_r};
        mul_b    = {{32{sr_r[31]}}, sr_r};
      end
      MS_DI_SI: begin
        mul_wide = 1'b0;
        mul_a    = {{31{di_r[32]}}, di_r};
        mul_b    = {{32{si_r[31]}}, si_r};
      end
      MS_DR_SI: begin
        mul_wide = 1'b0;
        mul_a    = {{31{dr_r[32]}}, dr_r};
        mul_b    = {{32{si_r[31]}}, si_r};
      end
      MS_DI_SR: begin
        mul_wide = 1'b0;
        mul_a    = {{31{di_r[32]}}, di_r};
        mul_b    = {{32{sr_r[31]}}, sr_r};
      end
      default: begin
        mul_wide = 1'b1;
      end
    endcase
  end

  // A product shifted right by 16 with the sign kept is the floored quotient.
  assign res_sh   = {mul_res[63], mul_res[63:16]};
  assign jump_sum = {2'b00, mul_res[47:0]} + {18'h0, row_r} + {19'h0, shift_r};
  assign len_sat  = (in_run_length > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : in_run_length;
  assign draw_now = $signed(33'h0_8000_0000) - $signed({1'b0, gen_r[63:32]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r       <= 64'h0;
      shift_r      <= 31'd1;
      gsize_r      <= 32'h0;
      sr_r         <= 32'sd65536;
      si_r         <= 32'sd0;
      cplx_r       <= 1'b1;
      left_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEED:         seed_r  <= cfg_data;
          CFG_START_SHIFT:  shift_r <= cfg_data[30:0];
          CFG_GLOBAL_SIZE:  gsize_r <= cfg_data[31:0];
          CFG_SCALE_REAL:   sr_r    <= cfg_data[31:0];
          CFG_SCALE_IMAG:   si_r    <= cfg_data[31:0];
          CFG_COMPLEX_MODE: cplx_r  <= cfg_data[0];
          default:          cplx_r  <= cplx_r;
        endcase
      end
      case (cmd.op)
        OP_ACCEPT: left_r <= len_sat;
        OP_EMIT: begin
          left_r       <= left_r - RUN_W'(1);
          out_strobe_r <= 1'b1;
        end
        default: left_r <= left_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        row_r <= in_start_row;
        col_r <= in_rhs_column;
        gen_r <= seed_r;
        pm_r  <= LCG_MUL;
        pi_r  <= LCG_INC;
      end
      OP_JUMP_LOAD: jump_r <= cplx_r ? {jump_sum[JUMP_W-2:0], 1'b0} : jump_sum;
      OP_GEN_JUMP:  gen_r <= mul_res + pi_r;
      OP_PI:        pi_r <= mul_res;
      OP_PM: begin
        pm_r   <= mul_res;
        jump_r <= {1'b0, jump_r[JUMP_W-1:1]};
      end
      OP_DRAW_R:    dr_r <= draw_now;
      OP_DRAW_I:    di_r <= draw_now;
      OP_GEN_STEP:  gen_r <= mul_res + LCG_INC;
      OP_RE_FIRST: begin
        re_r <= res_sh;
        im_r <= '0;
      end
      OP_RE_SUB:    re_r <= re_r - res_sh;
      OP_IM_FIRST:  im_r <= res_sh;
      OP_IM_ADD:    im_r <= im_r + res_sh;
      OP_EMIT: begin
        out_re_r   <= re_r;
        out_im_r   <= im_r;
        out_last_r <= (left_r == RUN_W'(1));
      end
      default: begin
        jump_r <= jump_r;
      end
    endcase
  end

  assign status.mul_done  = mul_done;
  assign status.jump_zero = (jump_r == '0);
  assign status.jump_lsb  = jump_r[0];
  assign status.left_zero = (left_r == '0);
  assign status.cplx      = cplx_r;

  assign out_strobe      = out_strobe_r;
  assign out_value_real  = out_re_r;
  assign out_value_imag  = out_im_r;
  assign out_last_in_run = out_last_r;

endmodule

`default_nettype wire

// File: rtl/lcg_skip_ahead_random_vector_top.sv
// LCG skip-ahead random vector generator, top level. The jump distance (up to
// 50 bits) is walked one bit at a time; each value takes one draw and one
// scaling product in real mode, or two draws and four in complex mode, on the
// shared 33x33 multiplier (three partial products per 64-bit product). One item
// at a time; busy stays high until the last result has been shown. Results
// cannot be stalled. Synchronous active-low reset restores the register defaults.
`default_nettype none

module lcg_skip_ahead_random_vector_top
  import lsrv_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           in_start_row,
  input  wire logic [15:0]           in_rhs_column,
  input  wire logic [RUN_W-1:0]      in_run_length,
  output logic                       out_strobe,
  output logic signed [VAL_W-1:0]    out_value_real,
  output logic signed [VAL_W-1:0]    out_value_imag,
  output logic                       out_last_in_run,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DAT_W-1:0]  cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  lsrv_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  lsrv_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_start_row    (in_start_row),
    .in_rhs_column   (in_rhs_column),
    .in_run_length   (in_run_length),
    .out_strobe      (out_strobe),
    .out_value_real  (out_value_real),
    .out_value_imag  (out_value_imag),
    .out_last_in_run (out_last_in_run)
  );

endmodule

`default_nettype wire
